[rtl/core/tea_pkg.sv]
// Shared types, command and status codes for the type-enforcement access checker.
`timescale 1ns / 1ps

package tea_pkg;

    // Rule table depth default and stored rule word width: {deny, kind, rights}
    localparam int RULE_ENTRIES = 16;
    localparam int RULE_W       = 65;

    // Command codes
    localparam logic [3:0] CMD_BAN_CAP   = 4'd0;
    localparam logic [3:0] CMD_SET_FLAGS = 4'd1;
    localparam logic [3:0] CMD_SET_LEVEL = 4'd2;
    localparam logic [3:0] CMD_ALLOW     = 4'd3;
    localparam logic [3:0] CMD_DENY      = 4'd4;
    localparam logic [3:0] CMD_SET_KIND  = 4'd5;
    localparam logic [3:0] CMD_CHECK_CAP = 4'd6;
    localparam logic [3:0] CMD_TRACE     = 4'd7;
    localparam logic [3:0] CMD_TRACEME   = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DENIED = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADCMD = 2'd3;

    // Flag and right bit positions
    localparam int FLAG_TE     = 0;
    localparam int FLAG_LEVEL  = 1;
    localparam int FLAG_LOCK   = 2;
    localparam int RIGHT_READ  = 0;
    localparam int RIGHT_WRITE = 1;

    // Request from the command sequencer to the rule scanner
    typedef struct packed {
        logic        start;
        logic        merge;
        logic        deny;
        logic        te_on;
        logic [31:0] kind;
        logic [31:0] mask;
    } scan_req_t;

    // Answer from the rule scanner
    typedef struct packed {
        logic        done;
        logic        full;
        logic [31:0] granted;
    } scan_rsp_t;

endpackage

[rtl/core/tea_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tea_ram #(
    parameter int WIDTH = tea_pkg::RULE_W,
    parameter int DEPTH = tea_pkg::RULE_ENTRIES,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    import tea_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/tea_rule_scan.sv]
// Rule table scanner: merges allow/deny rules and accumulates rights, one entry a cycle.
`timescale 1ns / 1ps

module tea_rule_scan #(
    parameter int ENTRIES = tea_pkg::RULE_ENTRIES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tea_pkg::scan_req_t req,
    output tea_pkg::scan_rsp_t rsp
);
    import tea_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

    localparam logic SC_IDLE = 1'b0;
    localparam logic SC_SCAN = 1'b1;

    logic              state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic              merge_reg, merge_next;
    logic              deny_flag_reg, deny_flag_next;
    logic [31:0]       kind_reg, kind_next;
    logic [31:0]       mask_reg, mask_next;
    logic [31:0]       allow_reg, allow_next;
    logic [31:0]       deny_acc_reg, deny_acc_next;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [RULE_W-1:0] wr_data;
    logic [RULE_W-1:0] rd_data;

    logic              e_deny;
    logic [31:0]       e_kind;
    logic [31:0]       e_rights;
    logic              have_entry;
    logic              last_entry;
    logic              kind_hit;
    logic              rule_hit;
    logic [31:0]       allow_acc;
    logic [31:0]       deny_acc;

    // Rule storage; entries below the fill count are in use
    tea_ram #(
        .WIDTH (RULE_W),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_rules (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_next),
        .rd_data (rd_data)
    );

    // Unpack the entry read for the current index
    assign e_deny     = rd_data[RULE_W-1];
    assign e_kind     = rd_data[63:32];
    assign e_rights   = rd_data[31:0];
    assign have_entry = CW'(idx_reg) < fill_reg;
    assign last_entry = (CW'(idx_reg) + CW'(1)) == fill_reg;
    assign kind_hit   = have_entry && (e_kind == kind_reg);
    assign rule_hit   = kind_hit && (e_deny == deny_flag_reg);
    assign allow_acc  = allow_reg | ((kind_hit && !e_deny) ? e_rights : 32'd0);
    assign deny_acc   = deny_acc_reg | ((kind_hit && e_deny) ? e_rights : 32'd0);

    // Step through the table; entries are claimed in order, so used ones form a prefix.
    // A merge writes back only at its end, so a read never overlaps a pending write.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        fill_next      = fill_reg;
        merge_next     = merge_reg;
        deny_flag_next = deny_flag_reg;
        kind_next      = kind_reg;
        mask_next      = mask_reg;
        allow_next     = allow_reg;
        deny_acc_next  = deny_acc_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = {deny_flag_reg, kind_reg, mask_reg};
        rsp            = '0;

        unique case (state_reg)
            SC_IDLE:
            begin
                if (req.start)
                begin
                    merge_next     = req.merge;
                    deny_flag_next = req.deny;
                    kind_next      = req.kind;
                    mask_next      = req.mask;
                    allow_next     = req.te_on ? 32'd0 : 32'hFFFF_FFFF;
                    deny_acc_next  = 32'd0;
                    idx_next       = '0;
                    state_next     = SC_SCAN;
                end
            end
            SC_SCAN:
            begin
                if (merge_reg)
                begin
                    if (rule_hit)
                    begin
                        // Merge rights into the matching rule
                        wr_en      = 1'b1;
                        wr_data    = {deny_flag_reg, kind_reg, e_rights | mask_reg};
                        rsp.done   = 1'b1;
                        state_next = SC_IDLE;
                    end
                    else if (have_entry && !last_entry)
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                    else if (fill_reg < FULL_COUNT)
                    begin
                        // Claim the first free entry
                        wr_en      = 1'b1;
                        wr_addr    = IW'(fill_reg);
                        fill_next  = fill_reg + CW'(1);
                        rsp.done   = 1'b1;
                        state_next = SC_IDLE;
                    end
                    else
                    begin
                        rsp.done   = 1'b1;
                        rsp.full   = 1'b1;
                        state_next = SC_IDLE;
                    end
                end
                else
                begin
                    allow_next    = allow_acc;
                    deny_acc_next = deny_acc;
                    if (have_entry && !last_entry)
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                    else
                    begin
                        rsp.done    = 1'b1;
                        rsp.granted = allow_acc & ~deny_acc;
                        state_next  = SC_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            idx_reg   <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            fill_reg  <= fill_next;
        end
    end

    // Request and accumulator payload
    always_ff @(posedge clk)
    begin
        merge_reg     <= merge_next;
        deny_flag_reg <= deny_flag_next;
        kind_reg      <= kind_next;
        mask_reg      <= mask_next;
        allow_reg     <= allow_next;
        deny_acc_reg  <= deny_acc_next;
    end

endmodule

[rtl/core/type_enforcement_access_checker.sv]
// Top level: command sequencer, task security context and result register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | input     | in_valid/in_ready  | command operand rights_mask other_level
//           |           |                    | other_kind want_read want_attach fs_creds
//   out     | output    | out_valid/out_ready| status granted_rights
//
// Register and capability commands are decoded and executed without a table walk;
// deny and trace commands, and allow commands while type enforcement is off, walk the
// rule RAM one entry a cycle, visiting at most the number of rules in use.
// One item is worked on at a time; the next is taken once the result sits in the
// output register, which holds it while out_ready is low.
// Reset clears the rule table (fill count), flags, level, own type and bans at once.
`timescale 1ns / 1ps

module type_enforcement_access_checker #(
    parameter int ENTRIES = tea_pkg::RULE_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  command,
    input  logic [31:0] operand,
    input  logic [31:0] rights_mask,
    input  logic [31:0] other_level,
    input  logic [31:0] other_kind,
    input  logic        want_read,
    input  logic        want_attach,
    input  logic        fs_creds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] granted_rights
);
    import tea_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_EXEC = 2'd1;
    localparam logic [1:0] T_WAIT = 2'd2;
    localparam logic [1:0] T_FIN  = 2'd3;

    logic [1:0]  state_reg, state_next;

    // Item registers
    logic [3:0]  cmd_reg;
    logic [31:0] op_reg;
    logic [31:0] mask_reg;
    logic [31:0] olev_reg;
    logic [31:0] okind_reg;
    logic        wread_reg;
    logic        wattach_reg;
    logic        fsc_reg;

    // Security context
    logic [31:0] flags_reg, flags_next;
    logic [31:0] level_reg, level_next;
    logic [31:0] own_kind_reg, own_kind_next;
    logic [63:0] caps_reg, caps_next;

    // Result staging and output
    logic [1:0]  res_status_reg, res_status_next;
    logic [31:0] res_granted_reg, res_granted_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg;
    logic [31:0] out_granted_reg;

    scan_req_t   scan_req;
    scan_rsp_t   scan_rsp;

    logic        accept;
    logic        out_load;
    logic        level_block;

    tea_rule_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scan_req),
        .rsp   (scan_rsp)
    );

    assign in_ready       = (state_reg == T_IDLE);
    assign accept         = in_valid && in_ready;
    assign out_load       = (state_reg == T_FIN) && (!out_valid_reg || out_ready);
    assign level_block    = flags_reg[FLAG_LEVEL] && (level_reg < olev_reg);
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign granted_rights = out_granted_reg;

    // Sequence each item: decode, optional table walk, hand off to the output
    always_comb
    begin
        state_next       = state_reg;
        flags_next       = flags_reg;
        level_next       = level_reg;
        own_kind_next    = own_kind_reg;
        caps_next        = caps_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        scan_req         = '0;
        scan_req.kind    = okind_reg;
        scan_req.mask    = mask_reg;
        scan_req.te_on   = flags_reg[FLAG_TE];

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    state_next = T_EXEC;
                end
            end
            T_EXEC:
            begin
                res_status_next  = ST_OK;
                res_granted_next = 32'd0;
                state_next       = T_FIN;
                unique case (cmd_reg) inside
                    CMD_BAN_CAP:
                    begin
                        caps_next = caps_reg | (64'd1 << op_reg[5:0]);
                    end
                    CMD_SET_FLAGS:
                    begin
                        flags_next = flags_reg | op_reg;
                    end
                    CMD_SET_LEVEL:
                    begin
                        if (flags_reg[FLAG_LEVEL] && (level_reg < op_reg))
                        begin
                            res_status_next = ST_DENIED;
                        end
                        else
                        begin
                            level_next = op_reg;
                        end
                    end
                    CMD_ALLOW:
                    begin
                        if (flags_reg[FLAG_TE])
                        begin
                            res_status_next = ST_DENIED;
                        end
                        else
                        begin
                            scan_req.start = 1'b1;
                            scan_req.merge = 1'b1;
                            scan_req.kind  = op_reg;
                            state_next     = T_WAIT;
                        end
                    end
                    CMD_DENY:
                    begin
                        scan_req.start = 1'b1;
                        scan_req.merge = 1'b1;
                        scan_req.deny  = 1'b1;
                        scan_req.kind  = op_reg;
                        state_next     = T_WAIT;
                    end
                    CMD_SET_KIND:
                    begin
                        if (flags_reg[FLAG_LOCK])
                        begin
                            res_status_next = ST_DENIED;
                        end
                        else
                        begin
                            own_kind_next = op_reg;
                        end
                    end
                    CMD_CHECK_CAP:
                    begin
                        if (caps_reg[op_reg[5:0]])
                        begin
                            res_status_next = ST_DENIED;
                        end
                    end
                    CMD_TRACE, CMD_TRACEME:
                    begin
                        scan_req.start = 1'b1;
                        state_next     = T_WAIT;
                    end
                    default:
                    begin
                        res_status_next = ST_BADCMD;
                    end
                endcase
            end
            T_WAIT:
            begin
                if (scan_rsp.done)
                begin
                    state_next = T_FIN;
                    case (cmd_reg) inside
                        CMD_TRACE:
                        begin
                            res_granted_next = scan_rsp.granted;
                            if (!fsc_reg && (level_block
                                || (wread_reg && !scan_rsp.granted[RIGHT_READ])
                                || (wattach_reg && !scan_rsp.granted[RIGHT_WRITE])))
                            begin
                                res_status_next = ST_DENIED;
                            end
                        end
                        CMD_TRACEME:
                        begin
                            res_granted_next = scan_rsp.granted;
                            if (level_block || (scan_rsp.granted[RIGHT_WRITE:RIGHT_READ] == 2'b00))
                            begin
                                res_status_next = ST_DENIED;
                            end
                        end
                        default:
                        begin
                            res_status_next = scan_rsp.full ? ST_FULL : ST_OK;
                        end
                    endcase
                end
            end
            T_FIN:
            begin
                if (out_load)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Hold the output item until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            level_reg     <= '0;
            own_kind_reg  <= '0;
            caps_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
            level_reg     <= level_next;
            own_kind_reg  <= own_kind_next;
            caps_reg      <= caps_next;
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= command;
            op_reg      <= operand;
            mask_reg    <= rights_mask;
            olev_reg    <= other_level;
            okind_reg   <= other_kind;
            wread_reg   <= want_read;
            wattach_reg <= want_attach;
            fsc_reg     <= fs_creds;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        if (out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= res_granted_reg;
        end
    end

    // The scanner answers only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_rsp.done |-> (state_reg == T_WAIT))
        else $error("rule scanner answered outside a table walk");

    // A full table is only reported for rule merges
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == T_FIN) && (res_status_reg == ST_FULL))
            |-> ((cmd_reg == CMD_ALLOW) || (cmd_reg == CMD_DENY)))
        else $error("table-full status on a command that does not merge");

    // Granted rights are zero except for trace checks
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == T_FIN) && (res_granted_reg != 32'd0))
            |-> ((cmd_reg == CMD_TRACE) || (cmd_reg == CMD_TRACEME)))
        else $error("nonzero granted rights on a non-trace command");

    // An accepted item is decoded in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == T_EXEC))
        else $error("accepted item not decoded");

endmodule
